// ----- sv/qbf_pkg.sv -----
// Shared constants and types of the quadratic Bezier flattener.
`timescale 1ns / 1ps
package qbf_pkg;

   localparam int SEGMENTS = 20;
   localparam int COORD_W  = 24;
   localparam int IDX_W    = $clog2(SEGMENTS + 1);
   localparam int DIFF_W   = COORD_W + 1;
   localparam int PROD_W   = DIFF_W + IDX_W + 1;
   localparam int MAG_W    = PROD_W - 1;
   localparam int RECIP_SH = 32;
   localparam int RECIP_W  = RECIP_SH + 1;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SH) / SEGMENTS);
   localparam int LERP_LAT = 4;
   localparam int PIPE_LAT = 2 * LERP_LAT;

   localparam logic [COORD_W-1:0] NONE_MARK = COORD_W'(-256);

   typedef struct packed {
      logic             vld;
      logic             last;
      logic [IDX_W-1:0] idx;
   } side_type;

endpackage

// ----- sv/qbf_lerp.sv -----
// Four-stage pipelined lerp: a + floor((b - a) * idx / SEGMENTS).
`timescale 1ns / 1ps
module qbf_lerp
   import qbf_pkg::*;
(
   input  logic                      clock,
   input  logic                      en,
   input  logic signed [COORD_W-1:0] a,
   input  logic signed [COORD_W-1:0] b,
   input  logic [IDX_W-1:0]          idx,
   output logic [COORD_W-1:0]        res
);

   logic signed [DIFF_W-1:0]  d1_ff;
   logic signed [DIFF_W-1:0]  d1_in;
   logic [IDX_W-1:0]          i1_ff;
   logic [COORD_W-1:0]        a1_ff;

   logic signed [PROD_W-1:0]  p2_ff;
   logic signed [PROD_W-1:0]  p2_in;
   logic [COORD_W-1:0]        a2_ff;

   logic                      neg2;
   logic [MAG_W-1:0]          u2;
   logic [MAG_W+RECIP_W-1:0]  recip_prod;
   logic [MAG_W-1:0]          q3_ff;
   logic [MAG_W-1:0]          u3_ff;
   logic                      neg3_ff;
   logic [COORD_W-1:0]        a3_ff;

   logic [MAG_W-1:0]          qs;
   logic [MAG_W-1:0]          rem;
   logic [MAG_W-1:0]          q;
   logic [COORD_W-1:0]        fl;
   logic [COORD_W-1:0]        res_ff;
   logic [COORD_W-1:0]        res_in;

   always_comb begin
      d1_in = DIFF_W'(b) - DIFF_W'(a);
      p2_in = d1_ff * $signed({1'b0, i1_ff});
      neg2  = p2_ff[PROD_W-1];
      u2    = neg2 ? ~p2_ff[MAG_W-1:0] : p2_ff[MAG_W-1:0];
      recip_prod = u2 * RECIP;
      qs    = MAG_W'(q3_ff * MAG_W'(SEGMENTS));
      rem   = u3_ff - qs;
      q     = (rem >= MAG_W'(SEGMENTS)) ? MAG_W'(q3_ff + 1'b1) : q3_ff;
      fl    = neg3_ff ? ~q[COORD_W-1:0] : q[COORD_W-1:0];
      res_in = a3_ff + fl;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d1_ff   <= d1_in;
         i1_ff   <= idx;
         a1_ff   <= a;
         p2_ff   <= p2_in;
         a2_ff   <= a1_ff;
         q3_ff   <= recip_prod[MAG_W+RECIP_SH-1:RECIP_SH];
         u3_ff   <= u2;
         neg3_ff <= neg2;
         a3_ff   <= a2_ff;
         res_ff  <= res_in;
      end
   end

   assign res = res_ff;

endmodule

// ----- sv/quadratic_bezier_flattener_unit.sv -----
// Top level of the quadratic Bezier flattener.
//
// The req channel takes one curve per beat: start, control and goal points,
// 24-bit signed with 8 fraction bits. A control point of (-256,-256) marks a
// straight move, which yields one rsp beat holding the goal point. Any other
// curve yields SEGMENTS (20) rsp beats, the de Casteljau points for
// t = 1/SEGMENTS .. 1, with tlast on the final point (equal to the goal).
// A sequencer holds the curve and issues one point index per cycle, unless
// stalled, into an eight-stage pipeline of two lerp levels (difference,
// multiply, reciprocal multiply, correct and add in each). A curve holds
// the sequencer until all SEGMENTS indices are issued, a straight move until
// its single index is, so req_tready is low until a curve's last index issues;
// the rsp side then carries one beat per cycle while rsp_tready is high.
// When rsp_tready is low with a beat waiting, the whole pipeline and the
// sequencer hold; nothing is lost or repeated. Reset clears the sequencer
// and all stage valid bits.
`timescale 1ns / 1ps
module quadratic_bezier_flattener_unit
   import qbf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [143:0] req_tdata,  // start_x, start_y, ctrl_x, ctrl_y, goal_x, goal_y
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,  // point_x, point_y
   output logic         rsp_tlast   // last_point
);

   logic [COORD_W-1:0] start_x, start_y, ctrl_x, ctrl_y, goal_x, goal_y;
   logic               none_mark;
   logic               en;
   logic               accept;
   logic               issue_last;

   logic               busy_ff, busy_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [COORD_W-1:0] sx_ff, sy_ff, cx_ff, cy_ff, gx_ff, gy_ff;

   side_type           side_ff [PIPE_LAT];
   side_type           side_in;

   logic [COORD_W-1:0] ax, ay, bx, by;
   logic [COORD_W-1:0] px, py;

   assign start_x = req_tdata[0*COORD_W +: COORD_W];
   assign start_y = req_tdata[1*COORD_W +: COORD_W];
   assign ctrl_x  = req_tdata[2*COORD_W +: COORD_W];
   assign ctrl_y  = req_tdata[3*COORD_W +: COORD_W];
   assign goal_x  = req_tdata[4*COORD_W +: COORD_W];
   assign goal_y  = req_tdata[5*COORD_W +: COORD_W];

   assign none_mark  = (ctrl_x == NONE_MARK) && (ctrl_y == NONE_MARK);
   assign en         = !side_ff[PIPE_LAT-1].vld || rsp_tready;
   assign issue_last = (idx_ff == IDX_W'(SEGMENTS));
   assign req_tready = en && (!busy_ff || issue_last);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (en && busy_ff) begin
         if (issue_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
      if (accept) begin
         busy_in = 1'b1;
         idx_in  = none_mark ? IDX_W'(SEGMENTS) : IDX_W'(1);
      end
      side_in.vld  = busy_ff;
      side_in.last = issue_last;
      side_in.idx  = idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= IDX_W'(1);
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   // straight move: collapse all three points onto the goal
   always_ff @(posedge clock) begin
      if (accept) begin
         sx_ff <= none_mark ? goal_x : start_x;
         sy_ff <= none_mark ? goal_y : start_y;
         cx_ff <= none_mark ? goal_x : ctrl_x;
         cy_ff <= none_mark ? goal_y : ctrl_y;
         gx_ff <= goal_x;
         gy_ff <= goal_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PIPE_LAT; k++) begin
            side_ff[k].vld <= 1'b0;
         end
      end else if (en) begin
         side_ff[0] <= side_in;
         for (int k = 1; k < PIPE_LAT; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   qbf_lerp u_lerp_ax (.clock, .en, .a(sx_ff), .b(cx_ff), .idx(idx_ff), .res(ax));
   qbf_lerp u_lerp_ay (.clock, .en, .a(sy_ff), .b(cy_ff), .idx(idx_ff), .res(ay));
   qbf_lerp u_lerp_bx (.clock, .en, .a(cx_ff), .b(gx_ff), .idx(idx_ff), .res(bx));
   qbf_lerp u_lerp_by (.clock, .en, .a(cy_ff), .b(gy_ff), .idx(idx_ff), .res(by));

   qbf_lerp u_lerp_px (.clock, .en, .a(ax), .b(bx), .idx(side_ff[LERP_LAT-1].idx), .res(px));
   qbf_lerp u_lerp_py (.clock, .en, .a(ay), .b(by), .idx(side_ff[LERP_LAT-1].idx), .res(py));

   assign rsp_tvalid = side_ff[PIPE_LAT-1].vld;
   assign rsp_tlast  = side_ff[PIPE_LAT-1].last;
   assign rsp_tdata  = {py, px};

endmodule

// ----- sv/qbf_checker.sv -----
// Port-level checks of the quadratic Bezier flattener, bound to the top level.
`timescale 1ns / 1ps
module qbf_checker
   import qbf_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [143:0] req_tdata,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [47:0]  rsp_tdata,
   input logic         rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp beat dropped under stall");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp beat changed under stall");

   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   a_curve_busy: assert property (@(posedge clock) disable iff (reset)
      (SEGMENTS > 1) && req_tvalid && req_tready &&
      ((req_tdata[71:48] != NONE_MARK) || (req_tdata[95:72] != NONE_MARK))
      |=> !req_tready)
      else $error("req taken while a curve is being issued");

endmodule

bind quadratic_bezier_flattener_unit qbf_checker u_qbf_checker (.*);

// ----- test/tb_quadratic_bezier_flattener_unit.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the quadratic Bezier flattener: random and corner curves.
module tb_quadratic_bezier_flattener_unit;
   import qbf_pkg::*;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               last;
   } waypoint_type;

   localparam logic [COORD_W-1:0] COORD_MAX = 24'h7FFFFF;
   localparam logic [COORD_W-1:0] COORD_MIN = 24'h800000;

   class waypoint_ledger;
      waypoint_type pending_points[$];
      int           mismatches;

      function new();
         mismatches = 0;
      endfunction

      static function longint coord(logic [COORD_W-1:0] v);
         return longint'(signed'(v));
      endfunction

      // a + floor((b - a) * i / SEGMENTS)
      static function longint lerp(longint a, longint b, longint i);
         longint n;
         n = (b - a) * i;
         if (n >= 0) return a + n / SEGMENTS;
         return a - ((-n + SEGMENTS - 1) / SEGMENTS);
      endfunction

      function void note_curve(logic [143:0] beat);
         longint       sx, sy, cx, cy, gx, gy, ax, ay, bx, by;
         waypoint_type wp;
         int           i;
         sx = coord(beat[23:0]);
         sy = coord(beat[47:24]);
         cx = coord(beat[71:48]);
         cy = coord(beat[95:72]);
         gx = coord(beat[119:96]);
         gy = coord(beat[143:120]);
         if (beat[71:48] == NONE_MARK && beat[95:72] == NONE_MARK) begin
            wp.x    = beat[119:96];
            wp.y    = beat[143:120];
            wp.last = 1'b1;
            pending_points.insert(pending_points.size(), wp);
         end else begin
            for (i = 1; i <= SEGMENTS; i++) begin
               ax = lerp(sx, cx, i);
               ay = lerp(sy, cy, i);
               bx = lerp(cx, gx, i);
               by = lerp(cy, gy, i);
               wp.x    = COORD_W'(lerp(ax, bx, i));
               wp.y    = COORD_W'(lerp(ay, by, i));
               wp.last = (i == SEGMENTS);
               pending_points.insert(pending_points.size(), wp);
            end
         end
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= 40) $display("%0t: waypoint check: %s", $time, what);
      endtask

      task check_point(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py, logic plast);
         waypoint_type wp;
         if (pending_points.size() == 0) begin
            report_mismatch($sformatf("unexpected beat x=%h y=%h last=%b", px, py, plast));
         end else begin
            wp = pending_points.pop_front();
            if (px !== wp.x)
               report_mismatch($sformatf("point_x %h, predicted %h", px, wp.x));
            if (py !== wp.y)
               report_mismatch($sformatf("point_y %h, predicted %h", py, wp.y));
            if (plast !== wp.last)
               report_mismatch($sformatf("last_point %b, predicted %b", plast, wp.last));
         end
      endtask
   endclass

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic [143:0] req_tdata  = '0;
   logic         rsp_tready = 1'b0;
   logic         req_tready;
   logic         rsp_tvalid;
   logic [47:0]  rsp_tdata;
   logic         rsp_tlast;

   int             send_idle_pct = 0;
   int             stall_pct     = 0;
   bit             hold_request  = 1'b0;
   waypoint_ledger ledger;

   quadratic_bezier_flattener_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) ledger.note_curve(req_tdata);
         if (rsp_tvalid && rsp_tready)
            ledger.check_point(rsp_tdata[23:0], rsp_tdata[47:24], rsp_tlast);
      end
   end

   // Drive rsp_tready; hold it low for a long stretch on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   function automatic logic [143:0] curve(logic [23:0] sx, logic [23:0] sy,
                                          logic [23:0] cx, logic [23:0] cy,
                                          logic [23:0] gx, logic [23:0] gy);
      return {gy, gx, cy, cx, sy, sx};
   endfunction

   function automatic logic [23:0] pick_coord();
      case ($urandom_range(3))
         0, 1: return 24'($urandom);
         2: return 24'($urandom_range(4095)) - 24'd2048;
         default: begin
            case ($urandom_range(4))
               0: return COORD_MAX;
               1: return COORD_MIN;
               2: return '0;
               3: return '1;
               default: return NONE_MARK;
            endcase
         end
      endcase
   endfunction

   function automatic logic [143:0] random_curve();
      int          kind;
      logic [23:0] cx, cy;
      kind = $urandom_range(99);
      cx   = pick_coord();
      cy   = pick_coord();
      if (kind < 15) begin
         cx = NONE_MARK;
         cy = NONE_MARK;
      end else if (kind < 22) begin
         cx = NONE_MARK;
      end else if (kind < 29) begin
         cy = NONE_MARK;
      end
      return curve(pick_coord(), pick_coord(), cx, cy, pick_coord(), pick_coord());
   endfunction

   task automatic send_beat(logic [143:0] beat);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= beat;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (ledger.pending_points.size() != 0);
   endtask

   initial begin
      int phase, n;
      ledger = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_beat(curve('0, '0, '0, '0, '0, '0));
      send_beat(curve(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
      send_beat(curve(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN));
      send_beat(curve(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX));
      send_beat(curve(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));
      send_beat(curve(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
      send_beat(curve('0, '0, NONE_MARK, NONE_MARK, COORD_MAX, COORD_MIN));
      send_beat(curve(COORD_MAX, COORD_MIN, NONE_MARK, NONE_MARK, COORD_MIN, COORD_MAX));
      send_beat(curve('1, '1, NONE_MARK, NONE_MARK, NONE_MARK, NONE_MARK));
      send_beat(curve('0, '0, NONE_MARK, '0, 24'd5120, 24'd2560));
      send_beat(curve('0, '0, '0, NONE_MARK, 24'd2560, 24'd5120));
      send_beat(curve('0, '0, '1, 24'd1, -24'sd3, 24'd5));
      send_beat(curve(24'd7, -24'sd7, -24'sd1, '1, -24'sd13, 24'd19));
      send_beat(curve(24'd300, 24'd300, 24'd300, 24'd300, 24'd300, 24'd300));
      send_beat(curve(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
      send_beat(curve(24'h555555, 24'hAAAAAA, 24'h333333, 24'hCCCCCC, 24'h0F0F0F, 24'hF0F0F0));
      send_beat(curve('1, COORD_MIN, 24'd1, COORD_MAX, -24'sd256, 24'd256));
      wait_drained();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 61; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 61; end
            default: begin send_idle_pct = 8; stall_pct = 8; end
         endcase
         for (n = 0; n < 103; n++) begin
            if (phase == 0 && n == 30) hold_request = 1'b1;
            if (n == 70) wait_drained();
            send_beat(random_curve());
         end
      end

      wait_drained();
      repeat (PIPE_LAT + 2 * SEGMENTS) @(posedge clock);
      if (ledger.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
